FILE: rtl/aes256ke_pkg.sv
// Shared types, constants and byte-substitution helpers for the AES-256 key schedule.
// No dependencies; the xform, cell, core and testbench use this package by scoped name.
package aes256ke_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumCell = 4;
  localparam int unsigned KeyWords = 8;
  localparam logic [3:0]  LastRound = 4'd14;

  typedef logic [WordW-1:0] word_t;

  // Control that the sequencer hands to every cell of the chain.
  typedef struct packed {
    logic load;
    logic advance;
  } cell_ctrl_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] Rcon0 = 8'h01;
  localparam logic [7:0] Rcon1 = 8'h02;
  localparam logic [7:0] Rcon2 = 8'h04;
  localparam logic [7:0] Rcon3 = 8'h08;
  localparam logic [7:0] Rcon4 = 8'h10;
  localparam logic [7:0] Rcon5 = 8'h20;
  localparam logic [7:0] Rcon6 = 8'h40;

  // Round constant for the even round pair index; the last index is never used.
  function automatic logic [7:0] rcon_of(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = Rcon0;
      3'd1: r = Rcon1;
      3'd2: r = Rcon2;
      3'd3: r = Rcon3;
      3'd4: r = Rcon4;
      3'd5: r = Rcon5;
      3'd6: r = Rcon6;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic word_t sub_word(input word_t w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte 0 sits in the low bits, so the byte rotation is a right rotate.
  function automatic word_t rot_word(input word_t w);
    return {w[7:0], w[31:8]};
  endfunction

endpackage

FILE: rtl/aes256ke_if.sv
// Valid/ready channel interfaces for the key input and the round-key output.
// Depends on nothing; payload widths are the fixed widths of the key and round-key words.
interface aes256ke_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_bytes_0_7;
  logic [63:0] key_bytes_8_15;
  logic [63:0] key_bytes_16_23;
  logic [63:0] key_bytes_24_31;

  modport source (output valid, key_bytes_0_7, key_bytes_8_15, key_bytes_16_23,
                  key_bytes_24_31, input ready);
  modport sink (input valid, key_bytes_0_7, key_bytes_8_15, key_bytes_16_23,
                key_bytes_24_31, output ready);
endinterface

interface aes256ke_round_if;
  logic        valid;
  logic        ready;
  logic [3:0]  round_number;
  logic [63:0] round_key_low;
  logic [63:0] round_key_high;
  logic        final_round;

  modport source (output valid, round_number, round_key_low, round_key_high, final_round,
                  input ready);
  modport sink (input valid, round_number, round_key_low, round_key_high, final_round,
                output ready);
endinterface

FILE: rtl/aes256ke_xform.sv
// Word transform that feeds the head of the cell chain: SubWord, with RotWord and rcon
// on even rounds. Depends on aes256ke_pkg.
module aes256ke_xform (
  input  aes256ke_pkg::word_t word_in,
  input  logic [3:0]          round_idx,
  output aes256ke_pkg::word_t word_out
);

  aes256ke_pkg::word_t rot_sub;

  assign rot_sub = aes256ke_pkg::sub_word(aes256ke_pkg::rot_word(word_in))
                 ^ {24'h0, aes256ke_pkg::rcon_of(round_idx[3:1])};

  assign word_out = round_idx[0] ? aes256ke_pkg::sub_word(word_in) : rot_sub;

endmodule

FILE: rtl/aes256ke_cell.sv
// One cell of the key-schedule chain: holds a word of the current round key and the
// word four places later. Depends on aes256ke_pkg.
module aes256ke_cell (
  input  logic                    clk,
  input  aes256ke_pkg::cell_ctrl_t ctrl,
  input  aes256ke_pkg::word_t     load_lo,
  input  aes256ke_pkg::word_t     load_hi,
  input  aes256ke_pkg::word_t     carry_in,
  output aes256ke_pkg::word_t     lo,
  output aes256ke_pkg::word_t     carry_out
);

  aes256ke_pkg::word_t hi;

  // The new word is the word eight back xor the word just before it.
  assign carry_out = lo ^ carry_in;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      lo <= load_lo;
      hi <= load_hi;
    end else if (ctrl.advance) begin
      lo <= hi;
      hi <= carry_out;
    end
  end

endmodule

FILE: rtl/aes256_key_expansion_core.sv
// AES-256 key schedule: one 256-bit key in, fifteen 128-bit round keys out.
// Depends on aes256ke_pkg, the channel interfaces, aes256ke_cell and aes256ke_xform.

// A key is taken as four 64-bit words and the block returns the 15 round keys of the
// standard AES-256 schedule, round 0 first, one round key per cycle while the output side
// is ready; the last one carries final_round. The single row of four cells yields four
// new key words per step. Keys follow one another with no gap: a one-key input buffer
// takes the next key while the current one is still being expanded, and it is loaded into
// the cells in the same cycle that the previous key's final round key is taken. A key
// accepted while idle passes through the input buffer and then the cells before round
// key 0 is shown. Nothing is kept between keys; reset clears only the handshake flags and
// the round counter. Round key bytes keep the key's order, byte 0 in bits 7:0.
module aes256_key_expansion_core (
  input  logic                    clk,
  input  logic                    rst,
  aes256ke_key_if.sink            key,
  aes256ke_round_if.source        round_key
);

  // Input buffer, holding one key in eight 32-bit words, word 0 first.
  logic [aes256ke_pkg::KeyWords-1:0][aes256ke_pkg::WordW-1:0] hold_words;
  logic hold_valid;

  // Schedule sequencer.
  logic       busy;
  logic [3:0] rnd;
  logic       out_fire;
  logic       last;
  logic       engine_take;
  aes256ke_pkg::cell_ctrl_t ctrl;

  // Cell chain signals.
  aes256ke_pkg::word_t cell_lo   [aes256ke_pkg::NumCell];
  aes256ke_pkg::word_t cell_carry[aes256ke_pkg::NumCell];
  aes256ke_pkg::word_t head_word;

  assign key.ready   = !hold_valid;
  assign out_fire    = busy && round_key.ready;
  assign last        = (rnd == aes256ke_pkg::LastRound);
  assign engine_take = hold_valid && (!busy || (out_fire && last));

  assign ctrl.load    = engine_take;
  assign ctrl.advance = out_fire && !last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (key.valid && key.ready) begin
      hold_valid <= 1'b1;
    end else if (engine_take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key.valid && key.ready) begin
      hold_words <= {key.key_bytes_24_31, key.key_bytes_16_23,
                     key.key_bytes_8_15, key.key_bytes_0_7};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= 4'd0;
    end else if (engine_take) begin
      busy <= 1'b1;
      rnd  <= 4'd0;
    end else if (out_fire && last) begin
      busy <= 1'b0;
    end else if (ctrl.advance) begin
      rnd <= rnd + 4'd1;
    end
  end

  // The head of the chain sees the last word of the eight-word window, transformed.
  // That word sits in cell 3's hi register, which the cell does not bring out, so a
  // shadow copy of it feeds the xform.
  aes256ke_pkg::word_t window_last;

  aes256ke_xform u_xform (
    .word_in   (window_last),
    .round_idx (rnd),
    .word_out  (head_word)
  );

  for (genvar c = 0; c < aes256ke_pkg::NumCell; c++) begin : g_cell
    aes256ke_pkg::word_t carry_in;
    if (c == 0) begin : g_head
      assign carry_in = head_word;
    end else begin : g_body
      assign carry_in = cell_carry[c-1];
    end

    aes256ke_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_lo   (hold_words[c]),
      .load_hi   (hold_words[c+aes256ke_pkg::NumCell]),
      .carry_in  (carry_in),
      .lo        (cell_lo[c]),
      .carry_out (cell_carry[c])
    );
  end

  // Word seven of the window lives in the last cell's hi register. It is kept here in a
  // shadow register that follows the same load and advance rule.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      window_last <= hold_words[aes256ke_pkg::KeyWords-1];
    end else if (ctrl.advance) begin
      window_last <= cell_carry[aes256ke_pkg::NumCell-1];
    end
  end

  assign round_key.valid          = busy;
  assign round_key.round_number   = rnd;
  assign round_key.round_key_low  = {cell_lo[1], cell_lo[0]};
  assign round_key.round_key_high = {cell_lo[3], cell_lo[2]};
  assign round_key.final_round    = last;

endmodule

FILE: rtl/aes256ke_checker.sv
// Port-level checks on the round-key sequence of the AES-256 key schedule core.
// Depends on aes256_key_expansion_core; attached to it by the bind at the end of the file.
module aes256ke_checker (
  input logic       clk,
  input logic       rst,
  input logic       rk_valid,
  input logic       rk_ready,
  input logic [3:0] rk_round,
  input logic       rk_final
);

  // The last marker stands exactly on round 14.
  a_final_marks_last: assert property (@(posedge clk) disable iff (rst)
    rk_valid |-> (rk_final == (rk_round == 4'd14)))
    else $error("final_round does not match round 14");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    rk_valid |-> (rk_round <= 4'd14))
    else $error("round number out of range");

  // After a round key other than the last is taken, the next one follows at once.
  a_round_steps: assert property (@(posedge clk) disable iff (rst)
    (rk_valid && rk_ready && !rk_final) |=>
      (rk_valid && (rk_round == $past(rk_round) + 4'd1)))
    else $error("round keys not delivered in order");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (rk_valid && !rk_ready) |=> (rk_valid && $stable(rk_round)))
    else $error("stalled round key changed");

endmodule

bind aes256_key_expansion_core aes256ke_checker u_aes256ke_checker (
  .clk      (clk),
  .rst      (rst),
  .rk_valid (round_key.valid),
  .rk_ready (round_key.ready),
  .rk_round (round_key.round_number),
  .rk_final (round_key.final_round)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the AES-256 key schedule block aes256_key_expansion_core.
// Depends on aes256ke_pkg, the key and round-key channel interfaces, and the core itself.
// Expected round keys come from a schedule model that builds its own S-box in GF(2^8).

// Holds the round keys still owed by the block and checks each one that arrives.
class round_key_board;

  typedef struct {
    logic [3:0]  round_number;
    logic [63:0] round_key_low;
    logic [63:0] round_key_high;
    logic        final_round;
  } round_key_t;

  localparam logic [7:0] AesPoly   = 8'h1b;
  localparam logic [7:0] AffineC   = 8'h63;
  localparam logic [7:0] RconFirst = 8'h01;

  logic [7:0] sbox_tab [256];
  round_key_t owed_rounds [$];
  int         mismatches;

  function new();
    mismatches = 0;
    build_sbox();
  endfunction

  function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    logic       hi;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      hi = a[7];
      a  = a << 1;
      if (hi) a ^= AesPoly;
      b  = b >> 1;
    end
    return p;
  endfunction

  function logic [7:0] rotl8(logic [7:0] b, int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  // S-box = affine transform of the multiplicative inverse, with 0 mapped to 0 first.
  function void build_sbox();
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (x != 0 && gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      end
      sbox_tab[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                    ^ AffineC;
    end
  endfunction

  function aes256ke_pkg::word_t subst_word(aes256ke_pkg::word_t w);
    return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
  endfunction

  // Expands one accepted key and queues its fifteen round keys in order.
  function void note_key(logic [3:0][63:0] k);
    aes256ke_pkg::word_t w [60];
    aes256ke_pkg::word_t t;
    logic [7:0]          rc;
    round_key_t          e;
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = k[i][31:0];
      w[2*i+1] = k[i][63:32];
    end
    rc = RconFirst;
    for (int i = aes256ke_pkg::KeyWords; i < 60; i++) begin
      t = w[i-1];
      if (i % aes256ke_pkg::KeyWords == 0) begin
        // Byte 0 is in the low bits, so the word rotation moves bits right.
        t  = subst_word({t[7:0], t[31:8]}) ^ {24'h0, rc};
        rc = rc << 1;
      end else if (i % aes256ke_pkg::KeyWords == 4) begin
        t = subst_word(t);
      end
      w[i] = w[i-aes256ke_pkg::KeyWords] ^ t;
    end
    for (int r = 0; r <= aes256ke_pkg::LastRound; r++) begin
      e.round_number   = r[3:0];
      e.round_key_low  = {w[4*r+1], w[4*r]};
      e.round_key_high = {w[4*r+3], w[4*r+2]};
      e.final_round    = (r == aes256ke_pkg::LastRound);
      owed_rounds.push_back(e);
    end
  endfunction

  task report(string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task check_round_key(logic [3:0] rn, logic [63:0] lo, logic [63:0] hi, logic fin);
    round_key_t e;
    if (owed_rounds.size() == 0) begin
      report($sformatf("round key %0d arrived with none outstanding", rn));
      return;
    end
    e = owed_rounds.pop_front();
    if (rn !== e.round_number)
      report($sformatf("round_number %0d, want %0d", rn, e.round_number));
    if (lo !== e.round_key_low)
      report($sformatf("round %0d low %h, want %h", e.round_number, lo, e.round_key_low));
    if (hi !== e.round_key_high)
      report($sformatf("round %0d high %h, want %h", e.round_number, hi, e.round_key_high));
    if (fin !== e.final_round)
      report($sformatf("round %0d final_round %b, want %b", e.round_number, fin,
                       e.final_round));
  endtask

endclass

module tb_top;

  logic clk;
  logic rst;

  // When calm is set neither side inserts idle cycles; it is forced on for the tail.
  bit calm;

  round_key_board board;

  aes256ke_key_if   key_ch ();
  aes256ke_round_if rk_ch ();

  aes256_key_expansion_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .key       (key_ch),
    .round_key (rk_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop. The slowest legal run (every round key held off by the longest stall
  // and every key preceded by the longest gap) is well under a tenth of this.
  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end

  // Presents one key after an optional idle gap and holds it until the block
  // takes it. All input changes happen on the falling edge; ready is sampled on the
  // rising edge, before the block's own registers update. When the next key follows
  // with no gap, valid simply stays high and only the payload changes.
  task automatic send_key(logic [3:0][63:0] k, int gap);
    repeat (gap) begin
      @(negedge clk);
      key_ch.valid = 1'b0;
    end
    @(negedge clk);
    key_ch.valid           = 1'b1;
    key_ch.key_bytes_0_7   = k[0];
    key_ch.key_bytes_8_15  = k[1];
    key_ch.key_bytes_16_23 = k[2];
    key_ch.key_bytes_24_31 = k[3];
    do @(posedge clk); while (key_ch.ready !== 1'b1);
    board.note_key(k);
  endtask

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 9);
  endfunction

  // One random 64-bit key field; plain zero and all-ones fields show up now and then
  // so that whole words of the schedule start from those values.
  function automatic logic [63:0] random_field();
    case ($urandom_range(0, 7))
      0:       return 64'h0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Round-key side: ready drops in bursts of random length so that the stalls land on
  // every round of the schedule. Every accepted word is handed to the board, which
  // compares it with the oldest outstanding round key.
  initial begin
    int stall_left;
    stall_left  = 0;
    rk_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rk_ch.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rk_ch.ready = 1'b0;
        stall_left  = $urandom_range(1, 9) - 1;
      end else begin
        rk_ch.ready = 1'b1;
      end
      @(posedge clk);
      if (!rst && rk_ch.valid === 1'b1 && rk_ch.ready === 1'b1)
        board.check_round_key(rk_ch.round_number, rk_ch.round_key_low,
                              rk_ch.round_key_high, rk_ch.final_round);
    end
  end

  initial begin
    logic [3:0][63:0] directed [$];
    logic [3:0][63:0] k;
    board                  = new();
    calm                   = 1'b0;
    rst                    = 1'b1;
    key_ch.valid           = 1'b0;
    key_ch.key_bytes_0_7   = 64'h0;
    key_ch.key_bytes_8_15  = 64'h0;
    key_ch.key_bytes_16_23 = 64'h0;
    key_ch.key_bytes_24_31 = 64'h0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed keys: the all-zero and all-ones extremes, the byte-counting key of the
    // standard's example (bytes 00..1f), alternating bit patterns, single bits at the
    // bottom of byte 0 and the top of byte 31, and keys whose halves differ so that the
    // rotate-and-substitute path and the substitute-only path see unlike inputs.
    directed.push_back({64'h0, 64'h0, 64'h0, 64'h0});
    directed.push_back({64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                        64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
    directed.push_back({64'h1f1e1d1c1b1a1918, 64'h1716151413121110,
                        64'h0f0e0d0c0b0a0908, 64'h0706050403020100});
    directed.push_back({64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
                        64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555});
    directed.push_back({64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa,
                        64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa});
    directed.push_back({64'h0, 64'h0, 64'h0, 64'h1});
    directed.push_back({64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h0});
    directed.push_back({64'hffff_ffff_ffff_ffff, 64'h0, 64'h0, 64'h0});
    directed.push_back({64'h0, 64'hffff_ffff_ffff_ffff, 64'h0, 64'hffff_ffff_ffff_ffff});
    directed.push_back({64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000,
                        64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000});
    directed.push_back({64'h6363_6363_6363_6363, 64'h6363_6363_6363_6363,
                        64'h6363_6363_6363_6363, 64'h6363_6363_6363_6363});
    foreach (directed[i]) send_key(directed[i], pick_gap());

    // Random keys in blocks of 32; roughly one block in four runs with no idling on
    // either side, and the last sixty keys go back to back at full rate.
    for (int n = 0; n < 448; n++) begin
      if (n % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n >= 388) calm = 1'b1;
      for (int f = 0; f < 4; f++) k[f] = random_field();
      send_key(k, pick_gap());
    end
    @(negedge clk);
    key_ch.valid = 1'b0;

    // Drain: wait for every owed round key, then keep watching the channel for strays.
    while (board.owed_rounds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/aes256ke_pkg.sv
rtl/aes256ke_if.sv
rtl/aes256ke_xform.sv
rtl/aes256ke_cell.sv
rtl/aes256_key_expansion_core.sv
rtl/aes256ke_checker.sv
verif/tb_top.sv
